// ===== hw/rtl/lbfs_pkg.sv =====
`timescale 1ns / 1ps

package lbfs_pkg;

    // fixed widths of the text stream and the configuration port
    localparam int BYTE_W     = 8;
    localparam int POS_W      = 16;
    localparam int MASK_W     = 64;
    localparam int MASK_IDX_W = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [BYTE_W-1:0] LINE_END     = 8'd10;
    localparam logic [BYTE_W-1:0] DELIM_RESET  = 8'd9;
    localparam logic [POS_W-1:0]  POS_MAX      = 16'hFFFF;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODE_FIELDS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_USE_LIST    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COMPLEMENT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_START = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_END   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_END_OPEN    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DELIMITER   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SELECT_MASK = 3'd7;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic read;
        logic send_flush;
        logic send_tail;
    } lbfs_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;
        logic flush_req;
        logic tail_pend;
        logic rd_last;
    } lbfs_sts_t;

endpackage

// ===== hw/rtl/line_byte_field_selector.sv =====
`timescale 1ns / 1ps

// Cut-style selector for a text stream, one byte per word. A word is taken whenever the controller
// is idle and the output register is empty or being drained, and it yields at most one result
// word unless it releases the buffered first field of a line. That happens in field mode at
// the first delimiter of a line (when field 0 is selected) or at a line end on a line with no
// delimiter; such a word then holds the input until the N buffered bytes (N up to
// FIRST_FIELD_MAX) and any trailing delimiter or line end have been sent. Each replayed
// byte is read from the buffer memory through a registered port and then moved to the
// output register. The last output marks the final result word caused by an input word.
// Configuration is to be written through a plain write port, only while the block is idle;
// the user must keep to this, as the block itself does not enforce it.

module line_byte_field_selector import lbfs_pkg::*;
#(
    parameter int FIRST_FIELD_MAX = 63,
    parameter int MASK_POSITIONS  = 64
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [BYTE_W-1:0]     in_byte,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [BYTE_W-1:0]     out_byte,
    output logic                  last
);

    lbfs_cmd_t cmd;
    lbfs_sts_t sts;

    // controller
    lbfs_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath
    lbfs_dp #(
        .FIRST_FIELD_MAX (FIRST_FIELD_MAX),
        .MASK_POSITIONS  (MASK_POSITIONS)
    ) u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_byte   (in_byte),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_byte  (out_byte),
        .last      (last),
        .cmd       (cmd),
        .sts       (sts)
    );

    // at most one datapath command per cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.accept, cmd.read, cmd.send_flush, cmd.send_tail}))
        else $error("more than one datapath command");

    // output register is never overwritten while a word waits
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.send_flush || cmd.send_tail) |-> sts.out_free)
        else $error("output overwritten");

    // a word that releases the first field blocks the input next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && sts.flush_req) |=> !in_ready)
        else $error("input taken during first field replay");

    // a plain line end is registered as the final output word
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (in_byte == LINE_END) && !sts.flush_req)
        |=> (out_valid && (out_byte == LINE_END) && last))
        else $error("line end not passed on");

endmodule

// ===== hw/rtl/lbfs_ctrl.sv =====
`timescale 1ns / 1ps

module lbfs_ctrl import lbfs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  lbfs_sts_t sts,
    output lbfs_cmd_t cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_SEND = 2'd2;
    localparam logic [1:0] S_TAIL = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // sequencing of accept, first field replay and trailing word
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = (state_reg == S_IDLE) && sts.out_free;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd.accept = 1'b1;
                    if (sts.flush_req)
                        state_next = S_READ;
                end
            end
            S_READ:
            begin
                cmd.read   = 1'b1;
                state_next = S_SEND;
            end
            S_SEND:
            begin
                if (sts.out_free)
                begin
                    cmd.send_flush = 1'b1;
                    if (!sts.rd_last)
                        state_next = S_READ;
                    else if (sts.tail_pend)
                        state_next = S_TAIL;
                    else
                        state_next = S_IDLE;
                end
            end
            S_TAIL:
            begin
                if (sts.out_free)
                begin
                    cmd.send_tail = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ===== hw/rtl/lbfs_dp.sv =====
`timescale 1ns / 1ps

module lbfs_dp import lbfs_pkg::*;
#(
    parameter int FIRST_FIELD_MAX = 63,
    parameter int MASK_POSITIONS  = 64
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [BYTE_W-1:0]     in_byte,
    input  logic                  out_ready,
    output logic                  out_valid,
    output logic [BYTE_W-1:0]     out_byte,
    output logic                  last,
    input  lbfs_cmd_t             cmd,
    output lbfs_sts_t             sts
);

    localparam int LEN_W  = $clog2(FIRST_FIELD_MAX + 1);
    localparam int ADDR_W = (FIRST_FIELD_MAX > 1) ? $clog2(FIRST_FIELD_MAX) : 1;

    // configuration registers
    logic              mode_reg;
    logic              use_list_reg;
    logic              complement_reg;
    logic [POS_W-1:0]  start_reg;
    logic [POS_W-1:0]  end_reg;
    logic              end_open_reg;
    logic [BYTE_W-1:0] delim_reg;
    logic [MASK_W-1:0] mask_reg;

    // line state
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic              dseen_reg, dseen_next;
    logic              emitted_reg, emitted_next;
    logic [LEN_W-1:0]  len_reg, len_next;

    // per word replay state
    logic [LEN_W-1:0]  flush_len_reg, flush_len_next;
    logic [LEN_W-1:0]  rd_idx_reg, rd_idx_next;
    logic              tail_pend_reg, tail_pend_next;
    logic [BYTE_W-1:0] tail_byte_reg;
    logic [BYTE_W-1:0] rd_data_reg;

    // output register
    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] out_byte_reg, out_byte_next;
    logic              last_reg, last_next;

    logic [BYTE_W-1:0] ff_mem [FIRST_FIELD_MAX];

    logic [POS_W-1:0]  pos_inc;
    logic              sel_pos, sel_zero, sel_inc;
    logic              flush_hit, tail_hit, emitted_mid, buf_we;
    logic [BYTE_W-1:0] tail_sel;
    logic [POS_W-1:0]  pos_acc;
    logic              dseen_acc, emitted_acc;
    logic [LEN_W-1:0]  len_acc;
    logic              direct_emit;

    function automatic logic sel_fn(input logic [POS_W-1:0] idx);
        logic hit;
        if (use_list_reg)
            hit = (idx < POS_W'(MASK_POSITIONS)) && mask_reg[idx[MASK_IDX_W-1:0]];
        else
            hit = (idx >= start_reg) && (end_open_reg || (idx <= end_reg));
        return complement_reg ? !hit : hit;
    endfunction

    // decision for the word at the input
    always_comb
    begin
        pos_inc     = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 1'b1;
        sel_pos     = sel_fn(pos_reg);
        sel_zero    = sel_fn('0);
        sel_inc     = sel_fn(pos_inc);
        flush_hit   = 1'b0;
        tail_hit    = 1'b0;
        emitted_mid = emitted_reg;
        buf_we      = 1'b0;
        tail_sel    = in_byte;
        pos_acc     = pos_reg;
        dseen_acc   = dseen_reg;
        emitted_acc = emitted_reg;
        len_acc     = len_reg;
        priority if (in_byte == LINE_END)
        begin
            flush_hit   = mode_reg && !dseen_reg;
            tail_hit    = 1'b1;
            tail_sel    = LINE_END;
            pos_acc     = '0;
            dseen_acc   = 1'b0;
            emitted_acc = 1'b0;
            len_acc     = '0;
        end
        else if (!mode_reg)
        begin
            tail_hit = sel_pos;
            pos_acc  = pos_inc;
        end
        else if (in_byte == delim_reg)
        begin
            flush_hit   = !dseen_reg && sel_zero;
            emitted_mid = emitted_reg || flush_hit;
            dseen_acc   = 1'b1;
            len_acc     = '0;
            pos_acc     = pos_inc;
            tail_hit    = sel_inc && emitted_mid;
            emitted_acc = emitted_mid || sel_inc;
            tail_sel    = delim_reg;
        end
        else if (!dseen_reg)
        begin
            if (len_reg < LEN_W'(FIRST_FIELD_MAX))
            begin
                buf_we  = 1'b1;
                len_acc = len_reg + 1'b1;
            end
        end
        else
        begin
            tail_hit = sel_pos;
        end
    end

    assign sts.out_free  = !out_valid_reg || out_ready;
    assign sts.flush_req = flush_hit && (len_reg != '0);
    assign sts.tail_pend = tail_pend_reg;
    assign sts.rd_last   = (rd_idx_reg == (flush_len_reg - 1'b1));

    assign direct_emit = cmd.accept && !sts.flush_req && tail_hit;

    // next values of line, replay and output state
    always_comb
    begin
        pos_next       = pos_reg;
        dseen_next     = dseen_reg;
        emitted_next   = emitted_reg;
        len_next       = len_reg;
        flush_len_next = flush_len_reg;
        rd_idx_next    = rd_idx_reg;
        tail_pend_next = tail_pend_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        last_next      = last_reg;
        if (cmd.accept)
        begin
            pos_next       = pos_acc;
            dseen_next     = dseen_acc;
            emitted_next   = emitted_acc;
            len_next       = len_acc;
            flush_len_next = len_reg;
            rd_idx_next    = '0;
            tail_pend_next = tail_hit;
        end
        else if (cmd.send_flush)
        begin
            rd_idx_next = rd_idx_reg + 1'b1;
        end
        priority if (direct_emit)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = tail_sel;
            last_next      = 1'b1;
        end
        else if (cmd.send_flush)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = rd_data_reg;
            last_next      = sts.rd_last && !tail_pend_reg;
        end
        else if (cmd.send_tail)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = tail_byte_reg;
            last_next      = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= 1'b0;
            use_list_reg   <= 1'b0;
            complement_reg <= 1'b0;
            start_reg      <= '0;
            end_reg        <= '0;
            end_open_reg   <= 1'b1;
            delim_reg      <= DELIM_RESET;
            mask_reg       <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MODE_FIELDS: mode_reg       <= cfg_data[0];
                REG_USE_LIST:    use_list_reg   <= cfg_data[0];
                REG_COMPLEMENT:  complement_reg <= cfg_data[0];
                REG_RANGE_START: start_reg      <= cfg_data[POS_W-1:0];
                REG_RANGE_END:   end_reg        <= cfg_data[POS_W-1:0];
                REG_END_OPEN:    end_open_reg   <= cfg_data[0];
                REG_DELIMITER:   delim_reg      <= cfg_data[BYTE_W-1:0];
                REG_SELECT_MASK: mask_reg       <= cfg_data[MASK_W-1:0];
                default:         mask_reg       <= mask_reg;
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            dseen_reg     <= 1'b0;
            emitted_reg   <= 1'b0;
            len_reg       <= '0;
            flush_len_reg <= '0;
            rd_idx_reg    <= '0;
            tail_pend_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            last_reg      <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            dseen_reg     <= dseen_next;
            emitted_reg   <= emitted_next;
            len_reg       <= len_next;
            flush_len_reg <= flush_len_next;
            rd_idx_reg    <= rd_idx_next;
            tail_pend_reg <= tail_pend_next;
            out_valid_reg <= out_valid_next;
            last_reg      <= last_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        if (cmd.accept)
            tail_byte_reg <= tail_sel;
    end

    // first field buffer, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.accept && buf_we)
            ff_mem[len_reg[ADDR_W-1:0]] <= in_byte;
        if (cmd.read)
            rd_data_reg <= ff_mem[rd_idx_reg[ADDR_W-1:0]];
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign last      = last_reg;

endmodule
